### rtl/core/mbbs_pkg.sv
// Shared types and constants for the multipart boundary delimiter scanner.
package mbbs_pkg;

	localparam int CMD_W  = 2;
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 6;
	localparam int KIND_W = 3;
	localparam int POS_W  = 7;

	// Input commands
	localparam logic [CMD_W-1:0] CMD_WR    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
	localparam logic [CMD_W-1:0] CMD_BODY  = 2'd2;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_DATA  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DELIM = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EOL   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ERR   = 3'd4;

	localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_DASH = 8'h2D;

	// CR LF '-' '-' in front of the boundary string
	localparam logic [POS_W-1:0] DELIM_HDR = 7'd4;

	typedef struct packed {
		logic              valid;
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] value;
		logic              last;
	} res_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [BYTE_W-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} mem_rd_t;

endpackage

### rtl/core/mbbs_mem.sv
// Boundary string store: one write port, one registered read port with write forwarding.
module mbbs_mem #(
	parameter int DEPTH = 60
) (
	input  logic                        clk,
	input  mbbs_pkg::mem_wr_t           wr,
	input  mbbs_pkg::mem_rd_t           rd,
	output logic [mbbs_pkg::BYTE_W-1:0] rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [mbbs_pkg::BYTE_W-1:0] store_q [DEPTH];
	logic [mbbs_pkg::BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			store_q[wr.addr[AW-1:0]] <= wr.data;
		end
		if (rd.en) begin
			// same-cycle write to the entry being read wins
			if (wr.en && wr.addr == rd.addr) begin
				rd_data_q <= wr.data;
			end else begin
				rd_data_q <= store_q[rd.addr[AW-1:0]];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/mbbs_ctrl.sv
// Scan sequencer: delimiter match state, mismatch replay and result generation.
module mbbs_ctrl #(
	parameter int MAX_LEN = 60
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [mbbs_pkg::CMD_W-1:0]  cmd,
	input  logic [mbbs_pkg::BYTE_W-1:0] value,
	input  logic [mbbs_pkg::IDX_W-1:0]  index,
	input  logic                        can_emit,
	output mbbs_pkg::res_t              res,
	output mbbs_pkg::mem_wr_t           mem_wr,
	output mbbs_pkg::mem_rd_t           mem_rd,
	input  logic [mbbs_pkg::BYTE_W-1:0] rd_data
);

	localparam logic [2:0] M_IDLE    = 3'd0;
	localparam logic [2:0] M_MATCH   = 3'd1;
	localparam logic [2:0] M_DASH1   = 3'd2;
	localparam logic [2:0] M_DASH2   = 3'd3;
	localparam logic [2:0] M_SKIP    = 3'd4;
	localparam logic [2:0] M_SKIP_CR = 3'd5;
	localparam logic [2:0] M_DATA    = 3'd6;

	localparam logic [1:0] P_IDLE   = 2'd0;
	localparam logic [1:0] P_REPLAY = 2'd1;
	localparam logic [1:0] P_TAIL   = 2'd2;

	localparam logic [mbbs_pkg::IDX_W-1:0] MAX_IDX = mbbs_pkg::IDX_W'(MAX_LEN);
	localparam logic [mbbs_pkg::POS_W-1:0] MAX_POS = mbbs_pkg::POS_W'(MAX_LEN);

	typedef struct packed {
		logic [2:0]                  mode;
		logic [1:0]                  start;
		logic [mbbs_pkg::POS_W-1:0]  pos;
		mbbs_pkg::res_t              res;
	} step_t;

	logic [2:0]                  mode_q, mode_d;
	logic [1:0]                  phase_q, phase_d;
	logic [mbbs_pkg::IDX_W-1:0]  len_q, len_d;
	logic [mbbs_pkg::POS_W-1:0]  pos_q, pos_d;
	logic [1:0]                  start_q, start_d;
	logic [mbbs_pkg::POS_W-1:0]  rp_q, rp_d;
	logic [mbbs_pkg::BYTE_W-1:0] c_q, c_d;

	logic [mbbs_pkg::POS_W-1:0]  cur, cur_d, cur_off, pos_inc, rp_inc, lim, start_ext;
	logic [mbbs_pkg::BYTE_W-1:0] db;
	logic                        take, c_q_crlf, rp_last;
	step_t                       st, nx;

	// Data byte: CR or LF opens a candidate, anything else passes through.
	function automatic step_t data_step(input logic [mbbs_pkg::BYTE_W-1:0] c, input step_t s);
		step_t r;
		r = s;
		if (c == mbbs_pkg::CH_CR) begin
			r.mode  = M_MATCH;
			r.start = 2'd0;
			r.pos   = 7'd1;
		end else if (c == mbbs_pkg::CH_LF) begin
			r.mode  = M_MATCH;
			r.start = 2'd1;
			r.pos   = 7'd2;
		end else begin
			r.mode      = M_DATA;
			r.res.valid = 1'b1;
			r.res.kind  = mbbs_pkg::KIND_DATA;
			r.res.value = c;
			r.res.last  = 1'b1;
		end
		return r;
	endfunction

	// Rest of the delimiter line: wait for LF or CR LF.
	function automatic step_t skip_step(input logic [mbbs_pkg::BYTE_W-1:0] c, input step_t s);
		step_t r;
		r = s;
		if (c == mbbs_pkg::CH_CR) begin
			r.mode = M_SKIP_CR;
		end else if (c == mbbs_pkg::CH_LF) begin
			r.mode      = M_DATA;
			r.res.valid = 1'b1;
			r.res.kind  = mbbs_pkg::KIND_EOL;
			r.res.value = '0;
			r.res.last  = 1'b1;
		end else begin
			r.mode = M_SKIP;
		end
		return r;
	endfunction

	assign in_ready  = (phase_q == P_IDLE) && can_emit;
	assign take      = in_valid && in_ready;
	assign start_ext = {5'd0, start_q};
	assign lim       = {1'b0, len_q} + mbbs_pkg::DELIM_HDR;
	assign pos_inc   = pos_q + 7'd1;
	assign rp_inc    = rp_q + 7'd1;
	assign rp_last   = (rp_inc == pos_q);
	assign c_q_crlf  = (c_q == mbbs_pkg::CH_CR) || (c_q == mbbs_pkg::CH_LF);

	// Delimiter byte at the cursor; boundary characters come from the store.
	assign cur = (phase_q == P_REPLAY) ? rp_q : pos_q;
	always_comb begin
		if (cur == 7'd0) begin
			db = mbbs_pkg::CH_CR;
		end else if (cur == 7'd1) begin
			db = mbbs_pkg::CH_LF;
		end else if (cur < mbbs_pkg::DELIM_HDR) begin
			db = mbbs_pkg::CH_DASH;
		end else begin
			db = rd_data;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		phase_d = phase_q;
		len_d   = len_q;
		pos_d   = pos_q;
		start_d = start_q;
		rp_d    = rp_q;
		c_d     = c_q;
		mem_wr  = '0;
		st      = '0;
		st.mode  = mode_q;
		st.start = start_q;
		st.pos   = pos_q;
		nx      = st;

		unique case (phase_q)
			P_IDLE: begin
				if (take) begin
					unique case (cmd)
						mbbs_pkg::CMD_WR: begin
							if (index < MAX_IDX) begin
								mem_wr.en   = 1'b1;
								mem_wr.addr = index;
								mem_wr.data = value;
							end
						end
						mbbs_pkg::CMD_BEGIN: begin
							len_d  = (index > MAX_IDX) ? MAX_IDX : index;
							nx.mode  = M_MATCH;
							nx.pos   = 7'd2;
							nx.start = 2'd2;
						end
						mbbs_pkg::CMD_BODY: begin
							unique case (mode_q) inside
								M_DATA: nx = data_step(value, st);
								M_MATCH: begin
									if (value == db) begin
										nx.pos = pos_inc;
										if (pos_inc >= lim) begin
											nx.mode      = M_DASH1;
											nx.res.valid = 1'b1;
											nx.res.kind  = mbbs_pkg::KIND_DELIM;
											nx.res.last  = 1'b1;
										end
									end else if (pos_q == start_ext) begin
										nx = data_step(value, st);
									end else begin
										phase_d = P_REPLAY;
										rp_d    = start_ext;
										c_d     = value;
									end
								end
								M_DASH1: begin
									if (value == mbbs_pkg::CH_DASH) begin
										nx.mode = M_DASH2;
									end else begin
										nx = skip_step(value, st);
									end
								end
								M_DASH2: begin
									if (value == mbbs_pkg::CH_DASH) begin
										nx.mode      = M_SKIP;
										nx.res.valid = 1'b1;
										nx.res.kind  = mbbs_pkg::KIND_CLOSE;
										nx.res.last  = 1'b1;
									end else begin
										nx = skip_step(value, st);
									end
								end
								M_SKIP, M_SKIP_CR: nx = skip_step(value, st);
								default: begin
									nx.mode      = M_IDLE;
									nx.res.valid = 1'b1;
									nx.res.kind  = mbbs_pkg::KIND_ERR;
									nx.res.last  = 1'b1;
								end
							endcase
						end
						default: ;
					endcase
					mode_d  = nx.mode;
					pos_d   = nx.pos;
					start_d = nx.start;
				end
			end
			P_REPLAY: begin
				if (can_emit) begin
					nx.res.valid = 1'b1;
					nx.res.kind  = mbbs_pkg::KIND_DATA;
					nx.res.value = db;
					nx.res.last  = rp_last && c_q_crlf;
					rp_d = rp_inc;
					if (rp_last) begin
						if (c_q_crlf) begin
							st      = data_step(c_q, st);
							mode_d  = st.mode;
							pos_d   = st.pos;
							start_d = st.start;
							phase_d = P_IDLE;
						end else begin
							mode_d  = M_DATA;
							phase_d = P_TAIL;
						end
					end
				end
			end
			P_TAIL: begin
				if (can_emit) begin
					nx.res.valid = 1'b1;
					nx.res.kind  = mbbs_pkg::KIND_DATA;
					nx.res.value = c_q;
					nx.res.last  = 1'b1;
					phase_d = P_IDLE;
				end
			end
			default: phase_d = P_IDLE;
		endcase
	end

	assign res = nx.res;

	// Read ahead for the next cursor so the store byte is ready when compared.
	assign cur_d       = (phase_d == P_REPLAY) ? rp_d : pos_d;
	assign cur_off     = cur_d - mbbs_pkg::DELIM_HDR;
	assign mem_rd.en   = (cur_d >= mbbs_pkg::DELIM_HDR) && (cur_off < MAX_POS);
	assign mem_rd.addr = cur_off[mbbs_pkg::IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			phase_q <= P_IDLE;
			len_q   <= '0;
			pos_q   <= '0;
			start_q <= '0;
			rp_q    <= '0;
		end else begin
			mode_q  <= mode_d;
			phase_q <= phase_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			rp_q    <= rp_d;
		end
	end

	always_ff @(posedge clk) begin
		c_q <= c_d;
	end

endmodule

### rtl/core/multipart_body_boundary_scanner_top.sv
// Top level of the multipart body boundary delimiter scanner.
// A result shows on the output register in the cycle after its input transaction.
// Throughput: one input transaction per cycle while the output is taken; a failed candidate
//   holds off input while its replayed delimiter bytes (up to MAX_BOUNDARY_LEN+3) go out as
//   data results, followed by the re-examined byte itself when it is not a CR or LF.
// Reset: arst_n clears match state, boundary length and the output valid; the boundary
//   store is not cleared and holds garbage until written.
module multipart_body_boundary_scanner_top #(
	parameter int MAX_BOUNDARY_LEN = 60
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mbbs_pkg::CMD_W-1:0]    cmd,
	input  logic [mbbs_pkg::BYTE_W-1:0]   value,
	input  logic [mbbs_pkg::IDX_W-1:0]    index,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mbbs_pkg::KIND_W-1:0]   kind,
	output logic [mbbs_pkg::BYTE_W-1:0]   value_res,
	output logic                          last
);

	mbbs_pkg::res_t              res;
	mbbs_pkg::mem_wr_t           mem_wr;
	mbbs_pkg::mem_rd_t           mem_rd;
	logic [mbbs_pkg::BYTE_W-1:0] rd_data;
	logic                        can_emit;

	logic                          out_valid_q;
	logic [mbbs_pkg::KIND_W-1:0]   kind_q;
	logic [mbbs_pkg::BYTE_W-1:0]   value_q;
	logic                          last_q;

	// The sequencer may hand over a new result whenever the output register frees up
	// in this cycle, so a result that is being taken never blocks a new input transaction.
	assign can_emit = !out_valid_q || out_ready;

	// Boundary characters live in a synchronous store; the sequencer reads one ahead.
	mbbs_mem #(
		.DEPTH (MAX_BOUNDARY_LEN)
	) u_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd      (mem_rd),
		.rd_data (rd_data)
	);

	// Match state machine, replay of partial delimiters on a mismatch.
	mbbs_ctrl #(
		.MAX_LEN (MAX_BOUNDARY_LEN)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.value    (value),
		.index    (index),
		.can_emit (can_emit),
		.res      (res),
		.mem_wr   (mem_wr),
		.mem_rd   (mem_rd),
		.rd_data  (rd_data)
	);

	// Output register: valid is control, the payload loads with each new result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			kind_q  <= res.kind;
			value_q <= res.value;
			last_q  <= res.last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value_res = value_q;
	assign last      = last_q;

endmodule

### rtl/core/mbbs_checker.sv
// Port-level checks for the scanner top level, bound in below.
module mbbs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [mbbs_pkg::CMD_W-1:0]  cmd,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [mbbs_pkg::KIND_W-1:0] kind,
	input logic [mbbs_pkg::BYTE_W-1:0] value_res,
	input logic                        last
);

	// only data results carry a byte
	a_nondata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != mbbs_pkg::KIND_DATA |-> value_res == '0)
		else $error("non-data result with nonzero byte");

	// a stuck output register must hold off new input transactions
	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	// store writes, begin and unused commands create no result
	a_silent_cmds: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd != mbbs_pkg::CMD_BODY && !out_valid |=> !out_valid)
		else $error("result from a non-body command");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value_res)
			&& $stable(last))
		else $error("stalled result changed");

endmodule

bind multipart_body_boundary_scanner_top mbbs_checker u_mbbs_checker (.*);
